[sv/kca_pkg.sv]
// kca_pkg: shared types and codes for the k-means codebook block.
// No dependencies; used by kca_front, kca_back and the top level.
`default_nettype none
package kca_pkg;

  localparam int VALUE_W = 16;
  localparam int DIST_W  = 39;
  localparam int SUM_W   = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WORDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 2'd1;

  localparam logic RES_ASSIGN = 1'b0;
  localparam logic RES_UPDATE = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SAMPLE,
    CMD_UPDATE
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [7:0]  widx;
    logic [6:0]  didx;
    logic [15:0] value;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  word;
    logic [38:0] sq_dist;
    logic [8:0]  empty;
  } res_t;

endpackage
`default_nettype wire

[sv/kca_fifo.sv]
// kca_fifo: small synchronous queue with registered storage.
// No package dependency.
`default_nettype none
module kca_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

[sv/kca_front.sv]
// kca_front: accepts input transactions, drops ignored ones, builds commands.
// Depends on kca_pkg.
`default_nettype none
module kca_front #(
  parameter int MAX_WORDS = 256,
  parameter int MAX_DIMS  = 128
) (
  input  wire logic        push_i,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  word_index_i,
  input  wire logic [6:0]  dim_index_i,
  input  wire logic [15:0] value_i,
  input  wire logic        last_i,
  input  wire logic        clearing_i,
  input  wire logic        q_full_i,
  output logic             full_o,
  output logic             cmd_push_o,
  output kca_pkg::cmd_t    cmd_o
);
  logic keep;
  logic widx_ok, didx_ok;

  assign full_o  = q_full_i || clearing_i;
  assign widx_ok = (32'(word_index_i) < MAX_WORDS);
  assign didx_ok = (32'(dim_index_i) < MAX_DIMS);

  always_comb begin
    cmd_o.widx  = word_index_i;
    cmd_o.didx  = dim_index_i;
    cmd_o.value = value_i;
    cmd_o.last  = last_i;
    cmd_o.kind  = kca_pkg::CMD_UPDATE;
    keep = 1'b0;
    case (func_i)
      kca_pkg::FUNC_LOAD: begin
        cmd_o.kind = kca_pkg::CMD_LOAD;
        keep = widx_ok && didx_ok;
      end
      kca_pkg::FUNC_SAMPLE: begin
        cmd_o.kind = kca_pkg::CMD_SAMPLE;
        keep = didx_ok;
      end
      kca_pkg::FUNC_UPDATE: begin
        cmd_o.kind = kca_pkg::CMD_UPDATE;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = push_i && !full_o && keep;
endmodule
`default_nettype wire

[sv/kca_div.sv]
// kca_div: restoring divider, one quotient bit per cycle.
// No package dependency.
`default_nettype none
module kca_div #(
  parameter int N = 40,
  parameter int M = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [N-1:0] dividend_i,
  input  wire logic [M-1:0] divisor_i,
  output logic              done_o,
  output logic [N-1:0]      quotient_o
);
  localparam int CW = $clog2(N + 1);

  logic run_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [N-1:0] dq_q;
  logic [M-1:0] rem_q, dvs_q;
  logic [M:0] trial, diff;
  logic take;

  assign trial = {rem_q, dq_q[N-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = (trial >= {1'b0, dvs_q});
  assign done_o = done_q;
  assign quotient_o = dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !run_q) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(N - 1)) begin
          run_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !run_q) begin
      dq_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= take ? diff[M-1:0] : trial[M-1:0];
      dq_q <= {dq_q[N-2:0], take};
    end
  end
endmodule
`default_nettype wire

[sv/kca_back.sv]
// kca_back: sequencer with codebook, sum, count and sample memories.
// Depends on kca_pkg and kca_div.
`default_nettype none
module kca_back #(
  parameter int MAX_WORDS  = 256,
  parameter int MAX_DIMS   = 128,
  parameter int COUNT_BITS = 24,
  localparam int NWW = $clog2(MAX_WORDS + 1),
  localparam int NDW = $clog2(MAX_DIMS + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_empty_i,
  input  wire kca_pkg::cmd_t  cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output kca_pkg::res_t       res_o,
  input  wire logic [NWW-1:0] nw_i,
  input  wire logic [NDW-1:0] nd_i,
  output logic                clearing_o
);
  localparam int TOTAL = MAX_WORDS * MAX_DIMS;
  localparam int AW = $clog2(TOTAL);
  localparam int WW = $clog2(MAX_WORDS);
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int VW = kca_pkg::VALUE_W;
  localparam int SW = kca_pkg::SUM_W;
  localparam int XW = kca_pkg::DIST_W;

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_S_RD  = 5'd2;
  localparam logic [4:0] ST_S_SQ  = 5'd3;
  localparam logic [4:0] ST_S_ACC = 5'd4;
  localparam logic [4:0] ST_S_CMP = 5'd5;
  localparam logic [4:0] ST_A_SET = 5'd6;
  localparam logic [4:0] ST_A_CRD = 5'd7;
  localparam logic [4:0] ST_A_CNT = 5'd8;
  localparam logic [4:0] ST_A_RD  = 5'd9;
  localparam logic [4:0] ST_A_WR  = 5'd10;
  localparam logic [4:0] ST_RES   = 5'd11;
  localparam logic [4:0] ST_U_CRD = 5'd12;
  localparam logic [4:0] ST_U_CNT = 5'd13;
  localparam logic [4:0] ST_U_RD  = 5'd14;
  localparam logic [4:0] ST_U_EL  = 5'd15;
  localparam logic [4:0] ST_U_DIV = 5'd16;

  logic [VW-1:0] code_mem [TOTAL];
  logic [SW-1:0] sum_mem [TOTAL];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_WORDS];
  logic [VW-1:0] smp_mem [MAX_DIMS];

  logic [4:0] st_q, st_d;
  logic [WW-1:0] w_q, w_d, best_q, best_d;
  logic [DW-1:0] d_q, d_d;
  logic [AW-1:0] base_q, base_d, bbase_q, bbase_d, clr_q, clr_d;
  logic [XW-1:0] acc_q, acc_d, bdist_q, bdist_d;
  logic [31:0] sq_q, sq_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [NWW-1:0] empty_q, empty_d;
  logic upd_q, upd_d;

  logic code_we, sum_we, cnt_we, smp_we;
  logic [AW-1:0] code_wa, sum_wa, elem_addr, load_addr;
  logic [VW-1:0] code_wd, code_rd_q, smp_rd_q;
  logic [SW-1:0] sum_wd, sum_rd_q;
  logic [WW-1:0] cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd, cnt_rd_q;

  logic [VW-1:0] diff;
  logic [XW:0] acc_sum;
  logic [SW:0] sum_add;
  logic last_dim, last_word, w_act, d_act, el_next;
  logic div_start, div_done;
  logic [SW-1:0] quot;

  assign elem_addr = base_q + AW'(d_q);
  assign load_addr = AW'(32'(cmd_i.widx) * MAX_DIMS + 32'(cmd_i.didx));
  assign diff = (smp_rd_q >= code_rd_q) ? smp_rd_q - code_rd_q : code_rd_q - smp_rd_q;
  assign acc_sum = {1'b0, acc_q} + (XW + 1)'(sq_q);
  assign sum_add = {1'b0, sum_rd_q} + (SW + 1)'(smp_rd_q);
  assign last_dim = (NDW'(d_q) == nd_i - NDW'(1));
  assign last_word = (NWW'(w_q) == nw_i - NWW'(1));
  assign w_act = (NWW'(w_q) < nw_i);
  assign d_act = (NDW'(d_q) < nd_i);
  assign clearing_o = (st_q == ST_CLR);

  kca_div #(
    .N(SW),
    .M(COUNT_BITS)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i(div_start),
    .dividend_i(sum_rd_q),
    .divisor_i(cnt_q),
    .done_o(div_done),
    .quotient_o(quot)
  );

  always_comb begin
    st_d = st_q;
    w_d = w_q;
    d_d = d_q;
    base_d = base_q;
    best_d = best_q;
    bbase_d = bbase_q;
    bdist_d = bdist_q;
    acc_d = acc_q;
    sq_d = sq_q;
    cnt_d = cnt_q;
    empty_d = empty_q;
    upd_d = upd_q;
    clr_d = clr_q;
    code_we = 1'b0;
    code_wa = elem_addr;
    code_wd = '0;
    sum_we = 1'b0;
    sum_wa = elem_addr;
    sum_wd = '0;
    cnt_we = 1'b0;
    cnt_wa = w_q;
    cnt_wd = '0;
    smp_we = 1'b0;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    div_start = 1'b0;
    el_next = 1'b0;
    case (st_q)
      ST_CLR: begin
        sum_we = 1'b1;
        sum_wa = clr_q;
        if (32'(clr_q) < MAX_WORDS) begin
          cnt_we = 1'b1;
          cnt_wa = WW'(clr_q);
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(TOTAL - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          w_d = '0;
          d_d = '0;
          base_d = '0;
          case (cmd_i.kind)
            kca_pkg::CMD_LOAD: begin
              code_we = 1'b1;
              code_wa = load_addr;
              code_wd = cmd_i.value;
            end
            kca_pkg::CMD_SAMPLE: begin
              smp_we = 1'b1;
              if (cmd_i.last) begin
                acc_d = '0;
                best_d = '0;
                bbase_d = '0;
                bdist_d = kca_pkg::DIST_MAX;
                upd_d = 1'b0;
                st_d = ST_S_RD;
              end
            end
            kca_pkg::CMD_UPDATE: begin
              empty_d = '0;
              upd_d = 1'b1;
              st_d = ST_U_CRD;
            end
            default: begin
              st_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_S_RD: st_d = ST_S_SQ;
      ST_S_SQ: begin
        sq_d = {16'b0, diff} * {16'b0, diff};
        st_d = ST_S_ACC;
      end
      ST_S_ACC: begin
        acc_d = acc_sum[XW] ? kca_pkg::DIST_MAX : acc_sum[XW-1:0];
        if (last_dim) begin
          st_d = ST_S_CMP;
        end else begin
          d_d = d_q + DW'(1);
          st_d = ST_S_RD;
        end
      end
      ST_S_CMP: begin
        if (acc_q < bdist_q) begin
          best_d = w_q;
          bdist_d = acc_q;
          bbase_d = base_q;
        end
        if (last_word) begin
          st_d = ST_A_SET;
        end else begin
          w_d = w_q + WW'(1);
          base_d = base_q + AW'(MAX_DIMS);
          d_d = '0;
          acc_d = '0;
          st_d = ST_S_RD;
        end
      end
      ST_A_SET: begin
        w_d = best_q;
        base_d = bbase_q;
        d_d = '0;
        st_d = ST_A_CRD;
      end
      ST_A_CRD: st_d = ST_A_CNT;
      ST_A_CNT: begin
        if (cnt_rd_q != {COUNT_BITS{1'b1}}) begin
          cnt_we = 1'b1;
          cnt_wd = cnt_rd_q + COUNT_BITS'(1);
          st_d = ST_A_RD;
        end else begin
          st_d = ST_RES;
        end
      end
      ST_A_RD: st_d = ST_A_WR;
      ST_A_WR: begin
        sum_we = 1'b1;
        sum_wd = sum_add[SW] ? kca_pkg::SUM_MAX : sum_add[SW-1:0];
        if (last_dim) begin
          st_d = ST_RES;
        end else begin
          d_d = d_q + DW'(1);
          st_d = ST_A_RD;
        end
      end
      ST_RES: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          st_d = ST_IDLE;
        end
      end
      ST_U_CRD: st_d = ST_U_CNT;
      ST_U_CNT: begin
        cnt_d = cnt_rd_q;
        if (w_act && cnt_rd_q == '0) begin
          empty_d = empty_q + NWW'(1);
        end
        d_d = '0;
        st_d = ST_U_RD;
      end
      ST_U_RD: st_d = ST_U_EL;
      ST_U_EL: begin
        if (w_act && d_act && cnt_q != '0) begin
          div_start = 1'b1;
          st_d = ST_U_DIV;
        end else begin
          code_we = w_act && d_act;
          sum_we = 1'b1;
          el_next = 1'b1;
        end
      end
      ST_U_DIV: begin
        if (div_done) begin
          code_we = 1'b1;
          code_wd = (|quot[SW-1:VW]) ? {VW{1'b1}} : quot[VW-1:0];
          sum_we = 1'b1;
          el_next = 1'b1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    if (el_next) begin
      if (d_q == DW'(MAX_DIMS - 1)) begin
        cnt_we = 1'b1;
        if (w_q == WW'(MAX_WORDS - 1)) begin
          st_d = ST_RES;
        end else begin
          w_d = w_q + WW'(1);
          base_d = base_q + AW'(MAX_DIMS);
          st_d = ST_U_CRD;
        end
      end else begin
        d_d = d_q + DW'(1);
        st_d = ST_U_RD;
      end
    end
  end

  always_comb begin
    res_o.kind    = upd_q ? kca_pkg::RES_UPDATE : kca_pkg::RES_ASSIGN;
    res_o.word    = upd_q ? 8'd0 : 8'(best_q);
    res_o.sq_dist = upd_q ? '0 : bdist_q;
    res_o.empty   = upd_q ? 9'(empty_q) : 9'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLR;
      clr_q <= '0;
      w_q <= '0;
      d_q <= '0;
      base_q <= '0;
      upd_q <= 1'b0;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      w_q <= w_d;
      d_q <= d_d;
      base_q <= base_d;
      upd_q <= upd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bbase_q <= bbase_d;
    bdist_q <= bdist_d;
    acc_q <= acc_d;
    sq_q <= sq_d;
    cnt_q <= cnt_d;
    empty_q <= empty_d;
  end

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[code_wa] <= code_wd;
    end
    code_rd_q <= code_mem[elem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_rd_q <= sum_mem[elem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[w_q];
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem[DW'(cmd_i.didx)] <= cmd_i.value;
    end
    smp_rd_q <= smp_mem[d_q];
  end
endmodule
`default_nettype wire

[sv/kmeans_codebook_assign_update.sv]
// Top level of the k-means codebook assign/update block: config registers,
// front decoder, command queue, back sequencer and result queue.
// Depends on kca_pkg, kca_front, kca_fifo, kca_back.
//
// After reset a clearing pass zeroes the sums and counts; full stays high
// meanwhile. A codeword load or a non-final sample element is handled in the
// idle state of the back sequencer. A final sample element starts a search
// by the single subtract-square-accumulate unit, reading one codeword element
// per step, then the read-modify-write of the winner's sums. A centroid update
// sweeps every memory entry and runs the bit-serial divider for each active
// element with a nonzero count.
`default_nettype none
module kmeans_codebook_assign_update #(
  parameter int MAX_WORDS  = 256,
  parameter int MAX_DIMS   = 128,
  parameter int COUNT_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  word_index_i,
  input  wire logic [6:0]  dim_index_i,
  input  wire logic [15:0] value_i,
  input  wire logic        last_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             result_kind_o,
  output logic [7:0]       nearest_word_o,
  output logic [38:0]      distance_o,
  output logic [8:0]       empty_words_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i
);
  localparam int NWW = $clog2(MAX_WORDS + 1);
  localparam int NDW = $clog2(MAX_DIMS + 1);
  localparam int CMDW = $bits(kca_pkg::cmd_t);
  localparam int RESW = $bits(kca_pkg::res_t);

  logic [8:0] words_q;
  logic [7:0] dims_q;
  logic [NWW-1:0] nw;
  logic [NDW-1:0] nd;

  logic clearing, q_full, q_empty, cmd_push, cmd_pop;
  kca_pkg::cmd_t cmd_in, cmd_out;
  logic [CMDW-1:0] cmd_bits;
  logic res_full, res_push;
  kca_pkg::res_t res_in, res_out;
  logic [RESW-1:0] res_bits;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= 9'd256;
      dims_q <= 8'd128;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == kca_pkg::CFG_WORDS) begin
        words_q <= cfg_data_i;
      end else if (cfg_index_i == kca_pkg::CFG_DIMS) begin
        dims_q <= cfg_data_i[7:0];
      end
    end
  end

  always_comb begin
    if (words_q == '0) begin
      nw = NWW'(1);
    end else if (32'(words_q) > MAX_WORDS) begin
      nw = NWW'(MAX_WORDS);
    end else begin
      nw = NWW'(words_q);
    end
    if (dims_q == '0) begin
      nd = NDW'(1);
    end else if (32'(dims_q) > MAX_DIMS) begin
      nd = NDW'(MAX_DIMS);
    end else begin
      nd = NDW'(dims_q);
    end
  end

  kca_front #(
    .MAX_WORDS(MAX_WORDS),
    .MAX_DIMS(MAX_DIMS)
  ) u_front (
    .push_i(push),
    .func_i,
    .word_index_i,
    .dim_index_i,
    .value_i,
    .last_i,
    .clearing_i(clearing),
    .q_full_i(q_full),
    .full_o(full),
    .cmd_push_o(cmd_push),
    .cmd_o(cmd_in)
  );

  kca_fifo #(
    .WIDTH(CMDW),
    .DEPTH(4)
  ) u_cmd_q (
    .clk_i,
    .rst_ni,
    .push_i(cmd_push),
    .data_i(cmd_in),
    .full_o(q_full),
    .pop_i(cmd_pop),
    .data_o(cmd_bits),
    .empty_o(q_empty)
  );

  assign cmd_out = kca_pkg::cmd_t'(cmd_bits);

  kca_back #(
    .MAX_WORDS(MAX_WORDS),
    .MAX_DIMS(MAX_DIMS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_empty_i(q_empty),
    .cmd_i(cmd_out),
    .cmd_pop_o(cmd_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o(res_in),
    .nw_i(nw),
    .nd_i(nd),
    .clearing_o(clearing)
  );

  kca_fifo #(
    .WIDTH(RESW),
    .DEPTH(2)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i(res_push),
    .data_i(res_in),
    .full_o(res_full),
    .pop_i(pop),
    .data_o(res_bits),
    .empty_o(empty)
  );

  assign res_out = kca_pkg::res_t'(res_bits);
  assign result_kind_o  = res_out.kind;
  assign nearest_word_o = res_out.word;
  assign distance_o     = res_out.sq_dist;
  assign empty_words_o  = res_out.empty;
endmodule
`default_nettype wire
